// ===== src/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_pkg - shared types and constants for the HSV to RGB12 LED packer
// Item format between the front classifier and the arithmetic back end,
// fixed field widths, and the reciprocal constants for the divide-free
// normalization of the p, q and t terms.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	// Input and output field widths
	localparam int unsigned IN_FIELD_W = 8;
	localparam int unsigned LEVEL_W    = 12;
	localparam int unsigned RECORD_W   = 48;
	localparam int unsigned IN_W       = 4 * IN_FIELD_W;                 // 32
	localparam int unsigned OUT_RAW_W  = 3 * LEVEL_W + RECORD_W;         // 84
	localparam int unsigned OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;      // 88

	// Hue sectors
	localparam int unsigned SECTOR_SPAN = 43;
	localparam int unsigned FRAC_FULL   = 42;
	localparam int unsigned FRAC_W      = 6;

	// Normalization: level = x * 273 / div, truncating, clamped to 4095
	localparam int unsigned LEVEL_MAX   = 4095;
	localparam int unsigned LEVEL_SCALE = 273;
	localparam int unsigned P_DIV       = 17 * 255;
	localparam int unsigned Q_DIV       = 17 * 255 * FRAC_FULL;
	localparam int unsigned Q_BASE      = 255 * FRAC_FULL;

	// Reciprocals: floor(273 * 2^k / div); the estimate is at most one low
	localparam int unsigned P_SHIFT = 24;
	localparam int unsigned Q_SHIFT = 30;
	localparam int unsigned RECIP_W = 21;
	localparam logic [RECIP_W-1:0] P_RECIP =
		RECIP_W'((64'(LEVEL_SCALE) << P_SHIFT) / 64'(P_DIV));
	localparam logic [RECIP_W-1:0] Q_RECIP =
		RECIP_W'((64'(LEVEL_SCALE) << Q_SHIFT) / 64'(Q_DIV));

	// Default depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	typedef enum logic [2:0] {
		SEC_RED_UP,     // red top, green rising
		SEC_GREEN_UP,   // green top, red falling
		SEC_CYAN_UP,    // green top, blue rising
		SEC_BLUE_UP,    // blue top, green falling
		SEC_MAG_UP,     // blue top, red rising
		SEC_RED_BACK    // red top, blue falling
	} sector_t;

	typedef enum logic [1:0] {
		KIND_COLOR,
		KIND_GRAY,
		KIND_BLACK
	} kind_t;

	typedef struct packed {
		logic [IN_FIELD_W-1:0] led;
		logic [IN_FIELD_W-1:0] sat;
		logic [IN_FIELD_W-1:0] bright;
		sector_t               sector;
		logic [FRAC_W-1:0]     frac;
		kind_t                 kind;
	} item_t;

endpackage

// ===== src/hsvrgb_front.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_front - input word classifier
// Splits hue into sector and fraction, marks gray and black words, and
// pushes the classified item into the queue while it has room.
// ----------------------------------------------------------------------------
module hsvrgb_front (
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [hsvrgb_pkg::IN_W-1:0] s_axis_tdata,  // led, hue, sat, bright
	input  logic                        queue_full,
	output logic                        push,
	output hsvrgb_pkg::item_t           push_item
);
	import hsvrgb_pkg::*;

	logic [IN_FIELD_W-1:0] hue;

	assign hue           = s_axis_tdata[2*IN_FIELD_W-1:IN_FIELD_W];
	assign s_axis_tready = !queue_full;
	assign push          = s_axis_tvalid && !queue_full;

	always_comb begin
		push_item.led    = s_axis_tdata[IN_FIELD_W-1:0];
		push_item.sat    = s_axis_tdata[3*IN_FIELD_W-1:2*IN_FIELD_W];
		push_item.bright = s_axis_tdata[4*IN_FIELD_W-1:3*IN_FIELD_W];

		// hue / 43 by compare chain
		if (hue < IN_FIELD_W'(SECTOR_SPAN)) begin
			push_item.sector = SEC_RED_UP;
			push_item.frac   = FRAC_W'(hue);
		end else if (hue < IN_FIELD_W'(2 * SECTOR_SPAN)) begin
			push_item.sector = SEC_GREEN_UP;
			push_item.frac   = FRAC_W'(hue - IN_FIELD_W'(SECTOR_SPAN));
		end else if (hue < IN_FIELD_W'(3 * SECTOR_SPAN)) begin
			push_item.sector = SEC_CYAN_UP;
			push_item.frac   = FRAC_W'(hue - IN_FIELD_W'(2 * SECTOR_SPAN));
		end else if (hue < IN_FIELD_W'(4 * SECTOR_SPAN)) begin
			push_item.sector = SEC_BLUE_UP;
			push_item.frac   = FRAC_W'(hue - IN_FIELD_W'(3 * SECTOR_SPAN));
		end else if (hue < IN_FIELD_W'(5 * SECTOR_SPAN)) begin
			push_item.sector = SEC_MAG_UP;
			push_item.frac   = FRAC_W'(hue - IN_FIELD_W'(4 * SECTOR_SPAN));
		end else begin
			push_item.sector = SEC_RED_BACK;
			push_item.frac   = FRAC_W'(hue - IN_FIELD_W'(5 * SECTOR_SPAN));
		end

		// zero saturation wins over zero brightness
		if (push_item.sat == '0) begin
			push_item.kind = KIND_GRAY;
		end else if (push_item.bright == '0) begin
			push_item.kind = KIND_BLACK;
		end else begin
			push_item.kind = KIND_COLOR;
		end
	end

endmodule

// ===== src/hsvrgb_queue.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_queue - short register queue between front and back
// First-word-fall-through; head item is visible while not empty.
// ----------------------------------------------------------------------------
module hsvrgb_queue #(
	parameter int unsigned DEPTH = hsvrgb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hsvrgb_pkg::item_t push_item,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output hsvrgb_pkg::item_t head_item
);
	import hsvrgb_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== src/hsvrgb_back.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_back - four-stage conversion pipeline
// s1: saturation products, s2: value products, s3: reciprocal estimates,
// s4: one-step correction, clamp, sector select and record packing.
// ----------------------------------------------------------------------------
module hsvrgb_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  hsvrgb_pkg::item_t            in_item,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [hsvrgb_pkg::OUT_W-1:0] m_axis_tdata  // red, green, blue, record
);
	import hsvrgb_pkg::*;

	localparam int unsigned SF_W  = 14;                 // s * frac <= 10710
	localparam int unsigned XP_W  = 16;                 // v * (255 - s)
	localparam int unsigned YQ_W  = 22;                 // v * (10710 - s*frac)
	localparam int unsigned EST_W = LEVEL_W + 1;
	localparam int unsigned PN_W  = XP_W + 9;           // x * 273
	localparam int unsigned QN_W  = YQ_W + 9;
	localparam int unsigned PM_W  = XP_W + RECIP_W;
	localparam int unsigned QM_W  = YQ_W + RECIP_W;

	logic en;

	// stage 1
	logic                  valid_s1;
	logic [IN_FIELD_W-1:0] led_s1, bright_s1, inv_sat_s1;
	sector_t               sector_s1;
	kind_t                 kind_s1;
	logic [SF_W-1:0]       sf_q_s1, sf_t_s1;

	// stage 2
	logic                  valid_s2;
	logic [IN_FIELD_W-1:0] led_s2, bright_s2;
	sector_t               sector_s2;
	kind_t                 kind_s2;
	logic [XP_W-1:0]       xp_s2;
	logic [YQ_W-1:0]       yq_s2, yt_s2;

	// stage 3
	logic                  valid_s3;
	logic [IN_FIELD_W-1:0] led_s3, bright_s3;
	sector_t               sector_s3;
	kind_t                 kind_s3;
	logic [EST_W-1:0]      pe_s3, qe_s3, te_s3;
	logic [PN_W-1:0]       pn_s3;
	logic [QN_W-1:0]       qn_s3, tn_s3;

	// stage 4 / output register
	logic                  valid_s4;
	logic [OUT_W-1:0]      data_s4;

	// stage 3 -> 4 combinational
	logic [PN_W-1:0]       p_rem;
	logic [QN_W-1:0]       q_rem, t_rem;
	logic [EST_W-1:0]      p_fix, q_fix, t_fix;
	logic [LEVEL_W-1:0]    p_lvl, q_lvl, t_lvl, top_lvl;
	logic [LEVEL_W-1:0]    red, green, blue;
	logic [RECORD_W-1:0]   record;

	assign en            = !valid_s4 || m_axis_tready;
	assign in_ready      = en;
	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = data_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			led_s1     <= in_item.led;
			bright_s1  <= in_item.bright;
			inv_sat_s1 <= IN_FIELD_W'(255) - in_item.sat;
			sector_s1  <= in_item.sector;
			kind_s1    <= in_item.kind;
			sf_q_s1    <= SF_W'(in_item.sat) * SF_W'(in_item.frac);
			sf_t_s1    <= SF_W'(in_item.sat) * SF_W'(FRAC_W'(FRAC_FULL) - in_item.frac);

			led_s2    <= led_s1;
			bright_s2 <= bright_s1;
			sector_s2 <= sector_s1;
			kind_s2   <= kind_s1;
			xp_s2     <= XP_W'(bright_s1) * XP_W'(inv_sat_s1);
			yq_s2     <= YQ_W'(bright_s1) * YQ_W'(SF_W'(Q_BASE) - sf_q_s1);
			yt_s2     <= YQ_W'(bright_s1) * YQ_W'(SF_W'(Q_BASE) - sf_t_s1);

			led_s3    <= led_s2;
			bright_s3 <= bright_s2;
			sector_s3 <= sector_s2;
			kind_s3   <= kind_s2;
			pe_s3     <= EST_W'((PM_W'(xp_s2) * PM_W'(P_RECIP)) >> P_SHIFT);
			qe_s3     <= EST_W'((QM_W'(yq_s2) * QM_W'(Q_RECIP)) >> Q_SHIFT);
			te_s3     <= EST_W'((QM_W'(yt_s2) * QM_W'(Q_RECIP)) >> Q_SHIFT);
			pn_s3     <= PN_W'(xp_s2) * PN_W'(LEVEL_SCALE);
			qn_s3     <= QN_W'(yq_s2) * QN_W'(LEVEL_SCALE);
			tn_s3     <= QN_W'(yt_s2) * QN_W'(LEVEL_SCALE);

			data_s4 <= {{(OUT_W - OUT_RAW_W){1'b0}}, record, blue, green, red};
		end
	end

	// estimate is exact or one low: fix with one remainder compare, then clamp
	always_comb begin
		p_rem = pn_s3 - PN_W'(pe_s3) * PN_W'(P_DIV);
		q_rem = qn_s3 - QN_W'(qe_s3) * QN_W'(Q_DIV);
		t_rem = tn_s3 - QN_W'(te_s3) * QN_W'(Q_DIV);
		p_fix = pe_s3 + EST_W'(p_rem >= PN_W'(P_DIV));
		q_fix = qe_s3 + EST_W'(q_rem >= QN_W'(Q_DIV));
		t_fix = te_s3 + EST_W'(t_rem >= QN_W'(Q_DIV));
		p_lvl = (p_fix > EST_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : p_fix[LEVEL_W-1:0];
		q_lvl = (q_fix > EST_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : q_fix[LEVEL_W-1:0];
		t_lvl = (t_fix > EST_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : t_fix[LEVEL_W-1:0];
		top_lvl = {bright_s3, 4'b0000};

		case (kind_s3)
			KIND_GRAY: begin
				red   = top_lvl;
				green = top_lvl;
				blue  = top_lvl;
			end
			KIND_BLACK: begin
				red   = '0;
				green = '0;
				blue  = '0;
			end
			default: begin
				case (sector_s3)
					SEC_RED_UP: begin
						red = top_lvl; green = t_lvl; blue = p_lvl;
					end
					SEC_GREEN_UP: begin
						red = q_lvl; green = top_lvl; blue = p_lvl;
					end
					SEC_CYAN_UP: begin
						red = p_lvl; green = top_lvl; blue = t_lvl;
					end
					SEC_BLUE_UP: begin
						red = p_lvl; green = q_lvl; blue = top_lvl;
					end
					SEC_MAG_UP: begin
						red = t_lvl; green = p_lvl; blue = top_lvl;
					end
					default: begin
						red = top_lvl; green = p_lvl; blue = q_lvl;
					end
				endcase
			end
		endcase

		record = {led_s3, red, green, blue, 4'b0000};
	end

endmodule

// ===== src/hsv_to_rgb12_led_packer.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb12_led_packer - HSV to 12-bit RGB with LED bus record packing
// Path: a word accepted on the slave side goes through the queue write, then
//   four pipeline stages; the last is the output register.
// Throughput: one word per cycle, sustained, while the master side takes them.
// Reset (arst_n low) empties the queue and drops all in-flight words.
// ----------------------------------------------------------------------------
module hsv_to_rgb12_led_packer #(
	parameter int unsigned QUEUE_DEPTH = hsvrgb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// slave side: led_index[7:0], hue[15:8], saturation[23:16], brightness[31:24]
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [hsvrgb_pkg::IN_W-1:0]  s_axis_tdata,
	// master side: red_level[11:0], green_level[23:12], blue_level[35:24],
	// packed_record[83:36], zero pad[87:84]
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [hsvrgb_pkg::OUT_W-1:0] m_axis_tdata
);
	import hsvrgb_pkg::*;

	// front -> queue
	logic  push;
	item_t push_item;
	logic  queue_full;

	// queue -> back
	logic  head_valid;
	logic  head_pop;
	item_t head_item;

	// Front: classifies hue into sector/fraction and flags gray/black words.
	// It only waits on queue room, never on the back end directly.
	hsvrgb_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.queue_full    (queue_full),
		.push          (push),
		.push_item     (push_item)
	);

	// Queue decouples the two sides so a master stall does not
	// immediately back up into the slave side.
	hsvrgb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (head_pop),
		.not_empty (head_valid),
		.head_item (head_item)
	);

	// Back: p/q/t arithmetic via reciprocal multiply and one-step fix,
	// sector select, pack. Whole pipe holds when the output reg is stuck.
	hsvrgb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (head_valid),
		.in_ready      (head_pop),
		.in_item       (head_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== src/hsvrgb_checker.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_checker - port-level checks for hsv_to_rgb12_led_packer
// Watches both stream sides; bound to the top level below.
// ----------------------------------------------------------------------------
module hsvrgb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [hsvrgb_pkg::OUT_W-1:0] m_axis_tdata
);
	import hsvrgb_pkg::*;

	logic [7:0] inflight_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// no output word without a matching input word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (inflight_q != '0))
		else $error("output word with nothing in flight");

	// stalled output word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled output word changed");

	// packed record agrees with the separate levels
	a_record_levels: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[75:64] == m_axis_tdata[11:0]) &&
		                  (m_axis_tdata[63:52] == m_axis_tdata[23:12]) &&
		                  (m_axis_tdata[51:40] == m_axis_tdata[35:24]))
		else $error("record levels differ from level fields");

	// low nibble of the record and the byte pad stay zero
	a_zero_bits: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[39:36] == 4'b0000) &&
		                  (m_axis_tdata[OUT_W-1:OUT_RAW_W] == '0))
		else $error("reserved bits set in output word");

endmodule

bind hsv_to_rgb12_led_packer hsvrgb_checker u_hsvrgb_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for hsv_to_rgb12_led_packer
// Drives HSV pixels with LED indexes into the slave stream and checks every
// master word (red, green, blue levels and the six-byte LED record) against
// an in-bench color predictor. Covers gray, black, all hue sector edges,
// full-rate streaming, a long output hold-off, and bursty random traffic.
// ----------------------------------------------------------------------------
module tb_top;
	import hsvrgb_pkg::*;

	localparam int STALL_LIMIT = 4000;   // cycles with no word moving on either side
	localparam int HOLDOFF_LEN = 400;    // long receiver hold-off, in cycles

	typedef logic [IN_FIELD_W-1:0] field_t;

	typedef struct packed {
		field_t led;
		field_t hue;
		field_t sat;
		field_t bright;
	} pixel_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]  red;
		logic [LEVEL_W-1:0]  green;
		logic [LEVEL_W-1:0]  blue;
		logic [RECORD_W-1:0] record;
	} led_word_t;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC
	} rx_mode_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	led_word_t pending_words[$];   // expected master words, oldest first
	int        error_count  = 0;
	int        pixels_sent  = 0;
	int        words_checked = 0;
	int        burst_left   = 0;
	bit        sender_idles = 1'b1;
	bit        rx_steady    = 1'b0;
	int        holdoff_request = 0;

	hsv_to_rgb12_led_packer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Color predictor
	// ------------------------------------------------------------------------

	// x * 273 / div, truncated, clamped to the 12-bit full scale
	function automatic int unsigned scale_level(longint unsigned x, longint unsigned div);
		longint unsigned r;
		r = (x * LEVEL_SCALE) / div;
		return (r > LEVEL_MAX) ? LEVEL_MAX : int'(r);
	endfunction

	function automatic led_word_t hsv_to_levels(pixel_t px);
		led_word_t    w;
		int unsigned  v, s, h, top, frac, p, q, t, r, g, b;
		sector_t      sec;
		v   = px.bright;
		s   = px.sat;
		h   = px.hue;
		top = v << 4;
		if (s == 0) begin
			// gray wins over black
			r = top; g = top; b = top;
		end else if (v == 0) begin
			r = 0; g = 0; b = 0;
		end else begin
			sec  = sector_t'(h / SECTOR_SPAN);
			frac = h - SECTOR_SPAN * (h / SECTOR_SPAN);
			p = scale_level(v * (255 - s), P_DIV);
			q = scale_level(v * (Q_BASE - s * frac), Q_DIV);
			t = scale_level(v * (Q_BASE - s * (FRAC_FULL - frac)), Q_DIV);
			case (sec)
				SEC_RED_UP:   begin r = top; g = t;   b = p;   end
				SEC_GREEN_UP: begin r = q;   g = top; b = p;   end
				SEC_CYAN_UP:  begin r = p;   g = top; b = t;   end
				SEC_BLUE_UP:  begin r = p;   g = q;   b = top; end
				SEC_MAG_UP:   begin r = t;   g = p;   b = top; end
				default:      begin r = top; g = p;   b = q;   end   // hue 255 lands here
			endcase
		end
		w.red    = r[LEVEL_W-1:0];
		w.green  = g[LEVEL_W-1:0];
		w.blue   = b[LEVEL_W-1:0];
		w.record = {px.led, w.red, w.green, w.blue, 4'h0};
		return w;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Weighted random pixel: gray, black, sector edges, saturation and brightness
	// extremes get extra weight, the rest is uniform over all bits.
	function automatic pixel_t random_pixel();
		pixel_t px;
		int     pick;
		int     edge_hues[12] = '{0, 42, 43, 85, 86, 128, 129, 171, 172, 214, 215, 255};
		px.led    = field_t'($urandom);
		px.hue    = field_t'($urandom);
		px.sat    = field_t'($urandom);
		px.bright = field_t'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 8)
			px.sat = '0;
		else if (pick < 16)
			px.bright = '0;
		else if (pick < 30)
			px.hue = field_t'(edge_hues[$urandom_range(0, 11)]);
		else if (pick < 36)
			px.sat = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h01;
		else if (pick < 40)
			px.bright = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h01;
		return px;
	endfunction

	// Offer one word on the slave side, wait for it to be taken, then queue
	// the expected master word. Valid stays high across back-to-back calls but for random idle gaps between bursts.
	task automatic send_pixel(input pixel_t px);
		int gap;
		@(negedge clk);
		if (sender_idles && burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {px.bright, px.sat, px.hue, px.led};
		do @(posedge clk); while (!s_axis_tready);
		pending_words.push_back(hsv_to_levels(px));
		pixels_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	task automatic test_gray_and_black();
		send_pixel('{led: 8'h00, hue: 8'd0,   sat: 8'd0,   bright: 8'd0});    // gray and black at once
		send_pixel('{led: 8'hFF, hue: 8'd37,  sat: 8'd0,   bright: 8'd255});  // full gray
		send_pixel('{led: 8'hAA, hue: 8'd200, sat: 8'd0,   bright: 8'd1});
		send_pixel('{led: 8'h55, hue: 8'd100, sat: 8'd1,   bright: 8'd0});    // black
		send_pixel('{led: 8'h11, hue: 8'd255, sat: 8'd255, bright: 8'd0});
		send_pixel('{led: 8'h03, hue: 8'd0,   sat: 8'd0,   bright: 8'd128});
	endtask

	// Both ends of every hue sector at full saturation and value, plus a few
	// mid-range and minimum points.
	task automatic test_sector_edges();
		int edge_hues[12] = '{0, 42, 43, 85, 86, 128, 129, 171, 172, 214, 215, 255};
		for (int i = 0; i < 12; i++)
			send_pixel('{led: field_t'(i * 21), hue: field_t'(edge_hues[i]),
				sat: 8'd255, bright: 8'd255});
		send_pixel('{led: 8'hFF, hue: 8'd255, sat: 8'd1,   bright: 8'd1});
		send_pixel('{led: 8'h80, hue: 8'd100, sat: 8'd128, bright: 8'd200});
		send_pixel('{led: 8'h01, hue: 8'd171, sat: 8'd254, bright: 8'd17});
	endtask

	// Back-to-back words with the receiver always ready
	task automatic test_full_rate(input int count);
		sender_idles = 1'b0;
		rx_steady    = 1'b1;
		repeat (count) send_pixel(random_pixel());
		rx_steady    = 1'b0;
		sender_idles = 1'b1;
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering;
	// the pipeline fills and the slave side must stall.
	task automatic test_output_holdoff(input int count);
		sender_idles    = 1'b0;
		holdoff_request = HOLDOFF_LEN;
		repeat (count) send_pixel(random_pixel());
		sender_idles    = 1'b1;
	endtask

	task automatic test_random_pixels(input int count);
		repeat (count) send_pixel(random_pixel());
	endtask

	// ------------------------------------------------------------------------
	// Receiver: hold-off when asked, always ready in steady mode, otherwise a
	// stall pattern whose mode is redrawn at random intervals.
	// ------------------------------------------------------------------------
	initial begin : rx_stalls
		int       hold_cnt;
		int       mode_left;
		int       stall_pct;
		int       period;
		int       duty;
		int       phase;
		rx_mode_t mode;
		hold_cnt  = 0;
		mode_left = 0;
		stall_pct = 0;
		period    = 1;
		duty      = 1;
		phase     = 0;
		mode      = RX_ALWAYS;
		forever begin
			@(negedge clk);
			if (holdoff_request > 0) begin
				hold_cnt        = holdoff_request;
				holdoff_request = 0;
			end
			if (hold_cnt > 0) begin
				m_axis_tready <= 1'b0;
				hold_cnt--;
			end else if (rx_steady) begin
				m_axis_tready <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(16, 128);
					mode      = rx_mode_t'($urandom_range(0, 2));
					stall_pct = $urandom_range(10, 70);
					period    = $urandom_range(2, 9);
					duty      = $urandom_range(1, period - 1);
					phase     = 0;
				end
				mode_left--;
				case (mode)
					RX_ALWAYS: m_axis_tready <= 1'b1;
					RX_RANDOM: m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
					default: begin
						m_axis_tready <= (phase < duty);
						phase = (phase + 1) % period;
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Checker: every master word against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_words
		led_word_t exp_w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word %h", $time, m_axis_tdata);
				error_count++;
			end else begin
				exp_w = pending_words.pop_front();
				words_checked++;
				if (m_axis_tdata[11:0] !== exp_w.red) begin
					$display("%0t: red expected %h got %h", $time, exp_w.red,
						m_axis_tdata[11:0]);
					error_count++;
				end
				if (m_axis_tdata[23:12] !== exp_w.green) begin
					$display("%0t: green expected %h got %h", $time, exp_w.green,
						m_axis_tdata[23:12]);
					error_count++;
				end
				if (m_axis_tdata[35:24] !== exp_w.blue) begin
					$display("%0t: blue expected %h got %h", $time, exp_w.blue,
						m_axis_tdata[35:24]);
					error_count++;
				end
				if (m_axis_tdata[83:36] !== exp_w.record) begin
					$display("%0t: record expected %h got %h", $time, exp_w.record,
						m_axis_tdata[83:36]);
					error_count++;
				end
				if (m_axis_tdata[OUT_W-1:84] !== '0) begin
					$display("%0t: pad expected 0 got %h", $time, m_axis_tdata[OUT_W-1:84]);
					error_count++;
				end
			end
		end
	end

	// Watchdog: too long with no word moving on either side ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d words outstanding",
					$time, quiet, pending_words.size());
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_gray_and_black();
		test_sector_edges();
		test_full_rate(100);
		test_output_holdoff(60);
		test_random_pixels(1570);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);   // room for a stray word past the pipeline depth

		$display("summary: %0d pixels sent, %0d words checked, %0d mismatches",
			pixels_sent, words_checked, error_count);
		$display("summary: gray, black, all sector edges, full rate and output hold-off");
		if (error_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/hsvrgb_pkg.sv
src/hsvrgb_front.sv
src/hsvrgb_queue.sv
src/hsvrgb_back.sv
src/hsv_to_rgb12_led_packer.sv
src/hsvrgb_checker.sv
dv/tb_top.sv
